FILE: rtl/core/scamc_pkg.sv
// ----------------------------------------------------------------------------
// Cache miss classifier package
// Shared widths, codes, types and the replacement LFSR step function.
// ----------------------------------------------------------------------------
`default_nettype none

package scamc_pkg;

   localparam int ADDR_W     = 32;
   localparam int OUTCOME_W  = 2;
   localparam int WAY_OUT_W  = 10;
   localparam int SET_OUT_W  = 10;
   localparam int CNT_W      = 32;
   localparam int LFSR_W     = 16;
   localparam int WAYS_CFG_W = 4;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [OUTCOME_W-1:0] OUTCOME_HIT        = 2'd0;
   localparam logic [OUTCOME_W-1:0] OUTCOME_COMPULSORY = 2'd1;
   localparam logic [OUTCOME_W-1:0] OUTCOME_CAPACITY   = 2'd2;

   localparam logic CSR_IDX_WAYS = 1'b0;
   localparam logic CSR_IDX_SEED = 1'b1;

   localparam logic [WAYS_CFG_W-1:0] WAYS_LOG2_RESET = 4'd2;
   localparam logic [LFSR_W-1:0]     SEED_RESET      = 16'd1;
   localparam logic [LFSR_W-1:0]     LFSR_TAPS       = 16'hB400;

   // Result of comparing one way against the lookup tag.
   typedef struct packed {
      logic hit;
      logic empty;
   } cmp_result_type;

   // One step of the Galois LFSR.
   function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] s);
      logic [LFSR_W-1:0] shifted;
      shifted = s >> 1;
      return s[0] ? (shifted ^ LFSR_TAPS) : shifted;
   endfunction

   // A zero seed would lock the LFSR, so it loads as one.
   function automatic logic [LFSR_W-1:0] seed_value(input logic [LFSR_W-1:0] s);
      return (s == '0) ? SEED_RESET : s;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/scamc_req_if.sv
// ----------------------------------------------------------------------------
// Request channel interface
// Valid/ready channel carrying one access address per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface scamc_req_if;
   import scamc_pkg::*;

   logic              valid;
   logic              ready;
   logic [ADDR_W-1:0] address;

   modport source (output valid, output address, input ready);
   modport sink   (input valid, input address, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/scamc_rsp_if.sv
// ----------------------------------------------------------------------------
// Response channel interface
// Valid/ready channel carrying one classification result per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface scamc_rsp_if;
   import scamc_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [OUTCOME_W-1:0] outcome;
   logic [WAY_OUT_W-1:0] way_hit_or_filled;
   logic [SET_OUT_W-1:0] set_used;
   logic [CNT_W-1:0]     hit_total;
   logic [CNT_W-1:0]     miss_total;
   logic [CNT_W-1:0]     compulsory_total;
   logic [CNT_W-1:0]     capacity_total;

   modport source (output valid, output outcome, output way_hit_or_filled,
                   output set_used, output hit_total, output miss_total,
                   output compulsory_total, output capacity_total, input ready);
   modport sink   (input valid, input outcome, input way_hit_or_filled,
                   input set_used, input hit_total, input miss_total,
                   input compulsory_total, input capacity_total, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/set_assoc_cache_miss_classifier_top.sv
// ----------------------------------------------------------------------------
// Set-associative cache miss classifier
// Classifies each access address as hit, compulsory miss or capacity miss.
// ----------------------------------------------------------------------------
// Usage: each request transaction on req_ch carries one byte address. The
// block answers with exactly one response transaction on rsp_ch holding the
// outcome, the way and set used, and the four running counters after it.
// The ways of the selected set are read from the tag memory one per
// iteration through a single comparator; each way passes a read state,
// then a compare state. req_ch.ready returns in the same cycle as
// rsp_ch.valid rises, so the next request waits until the current access
// has been answered.
// Only one access is in flight; req_ch.ready is high only while idle.
// The response sits in an output register, so a new request is accepted
// while the previous response still waits; a stalled receiver holds the
// finished result of the next access until the register frees.
// After reset the tag memory is cleared one entry per cycle over all
// 2**floor(log2(LINES)) entries; no request is accepted until it is done.
// Registers on the csr_ port: 0x0 ways_log2, 0x4 replace_seed (also reloads
// the replacement LFSR). Write them only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module set_assoc_cache_miss_classifier_top #(
   parameter int LINES      = 1024,
   parameter int LINE_BYTES = 64,
   parameter int ADDR_BITS  = 32
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   scamc_req_if.sink                              req_ch,
   scamc_rsp_if.source                            rsp_ch,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [scamc_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  wire logic [scamc_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic      [scamc_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                                   csr_pready
);
   import scamc_pkg::*;

   localparam int L        = $clog2(LINES + 1) - 1;
   localparam int OFF_BITS = $clog2(LINE_BYTES + 1) - 1;
   localparam int AW       = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
   localparam int BLK_W    = AW - OFF_BITS;
   localparam int TAG_W    = BLK_W;
   localparam int EXT_W    = BLK_W + L;
   localparam int SB_W     = $clog2(L + 1);
   localparam int ENTRY_W  = TAG_W + 1;

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_READ  = 3'd2;
   localparam logic [2:0] ST_CMP   = 3'd3;
   localparam logic [2:0] ST_FILL  = 3'd4;
   localparam logic [2:0] ST_DONE  = 3'd5;

   logic [2:0]            state_ff, state_in;
   logic [L-1:0]          clr_ff, clr_in;
   logic [ADDR_W-1:0]     addr_ff, addr_in;
   logic [L-1:0]          way_ff, way_in;
   logic                  empty_found_ff, empty_found_in;
   logic [L-1:0]          empty_way_ff, empty_way_in;
   logic [L-1:0]          chosen_ff, chosen_in;
   logic [OUTCOME_W-1:0]  outcome_ff, outcome_in;

   logic [WAYS_CFG_W-1:0] ways_log2_ff, ways_log2_in;
   logic [LFSR_W-1:0]     seed_ff, seed_in;
   logic [LFSR_W-1:0]     lfsr_ff, lfsr_in;

   logic [CNT_W-1:0]      hits_ff, hits_in;
   logic [CNT_W-1:0]      misses_ff, misses_in;
   logic [CNT_W-1:0]      comp_ff, comp_in;
   logic [CNT_W-1:0]      cap_ff, cap_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [OUTCOME_W-1:0]  rsp_outcome_ff, rsp_outcome_in;
   logic [WAY_OUT_W-1:0]  rsp_way_ff, rsp_way_in;
   logic [SET_OUT_W-1:0]  rsp_set_ff, rsp_set_in;

   // Lookup geometry
   logic [4:0]            wl_wide;
   logic [SB_W-1:0]       wl;
   logic [SB_W-1:0]       set_bits;
   logic [L-1:0]          ways_mask;
   logic [L-1:0]          set_mask;
   logic [EXT_W-1:0]      blk_ext;
   logic [EXT_W-1:0]      blk_shift;
   logic [TAG_W-1:0]      tag;
   logic [L-1:0]          set_idx;
   logic [L-1:0]          base;
   logic [L-1:0]          victim_way;
   logic [L+LFSR_W-1:0]   lfsr_ext;
   logic [LFSR_W-1:0]     lfsr_next;
   logic [L+WAY_OUT_W-1:0] way_ext;
   logic [L+SET_OUT_W-1:0] set_ext;

   // Memory and compare unit
   logic                  wr_en;
   logic [L-1:0]          wr_index;
   logic [ENTRY_W-1:0]    wr_data;
   logic [L-1:0]          rd_index;
   logic [ENTRY_W-1:0]    rd_data;
   cmp_result_type        cmp;

   logic                  req_fire;
   logic                  csr_write;
   logic                  rsp_free;

   scamc_tag_ram #(
      .INDEX_W (L),
      .DATA_W  (ENTRY_W)
   ) u_tag_ram (
      .clock    (clock),
      .wr_en    (wr_en),
      .wr_index (wr_index),
      .wr_data  (wr_data),
      .rd_index (rd_index),
      .rd_data  (rd_data)
   );

   scamc_way_cmp #(
      .TAG_W (TAG_W)
   ) u_way_cmp (
      .entry_valid (rd_data[ENTRY_W-1]),
      .entry_tag   (rd_data[TAG_W-1:0]),
      .lookup_tag  (tag),
      .result      (cmp)
   );

   // Geometry of the current access; ways_log2 saturates at log2 of the lines.
   always_comb begin
      wl_wide   = 5'(ways_log2_ff);
      wl        = (wl_wide > 5'(L)) ? SB_W'(L) : SB_W'(wl_wide);
      set_bits  = SB_W'(L) - wl;
      ways_mask = ~({L{1'b1}} << wl);
      set_mask  = ~({L{1'b1}} << set_bits);
      blk_ext   = EXT_W'(addr_ff[AW-1:OFF_BITS]);
      blk_shift = blk_ext >> set_bits;
      tag       = blk_shift[TAG_W-1:0];
      set_idx   = blk_ext[L-1:0] & set_mask;
      base      = set_idx << wl;
      lfsr_next = lfsr_step(lfsr_ff);
      lfsr_ext  = (L + LFSR_W)'(lfsr_next);
      victim_way = lfsr_ext[L-1:0] & ways_mask;
      way_ext   = (L + WAY_OUT_W)'(chosen_ff);
      set_ext   = (L + SET_OUT_W)'(set_idx);
   end

   assign req_fire  = req_ch.valid && req_ch.ready;
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign rsp_free  = !rsp_valid_ff || rsp_ch.ready;

   // Sequencer
   always_comb begin
      state_in       = state_ff;
      clr_in         = clr_ff;
      addr_in        = addr_ff;
      way_in         = way_ff;
      empty_found_in = empty_found_ff;
      empty_way_in   = empty_way_ff;
      chosen_in      = chosen_ff;
      outcome_in     = outcome_ff;
      lfsr_in        = lfsr_ff;
      hits_in        = hits_ff;
      misses_in      = misses_ff;
      comp_in        = comp_ff;
      cap_in         = cap_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ch.ready;
      rsp_outcome_in = rsp_outcome_ff;
      rsp_way_in     = rsp_way_ff;
      rsp_set_in     = rsp_set_ff;
      wr_en          = 1'b0;
      wr_index       = base | chosen_ff;
      wr_data        = {1'b1, tag};
      rd_index       = base | way_ff;

      case (state_ff)
         ST_CLEAR: begin
            wr_en    = 1'b1;
            wr_index = clr_ff;
            wr_data  = '0;
            clr_in   = clr_ff + 1'b1;
            if (&clr_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               addr_in        = req_ch.address;
               way_in         = '0;
               empty_found_in = 1'b0;
               state_in       = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (cmp.hit) begin
               outcome_in = OUTCOME_HIT;
               chosen_in  = way_ff;
               state_in   = ST_DONE;
            end else begin
               if (cmp.empty && !empty_found_ff) begin
                  empty_found_in = 1'b1;
                  empty_way_in   = way_ff;
               end
               if (way_ff == ways_mask) begin
                  state_in = ST_FILL;
               end else begin
                  way_in   = way_ff + 1'b1;
                  state_in = ST_READ;
               end
            end
         end
         ST_FILL: begin
            // The first empty way is filled; a full set evicts an LFSR pick.
            if (empty_found_ff) begin
               outcome_in = OUTCOME_COMPULSORY;
               chosen_in  = empty_way_ff;
            end else begin
               outcome_in = OUTCOME_CAPACITY;
               chosen_in  = victim_way;
               lfsr_in    = lfsr_next;
            end
            wr_en    = 1'b1;
            wr_index = base | chosen_in;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_free) begin
               if (outcome_ff == OUTCOME_HIT) begin
                  hits_in = hits_ff + 1'b1;
               end else begin
                  misses_in = misses_ff + 1'b1;
                  if (outcome_ff == OUTCOME_COMPULSORY) begin
                     comp_in = comp_ff + 1'b1;
                  end else begin
                     cap_in = cap_ff + 1'b1;
                  end
               end
               rsp_valid_in   = 1'b1;
               rsp_outcome_in = outcome_ff;
               rsp_way_in     = way_ext[WAY_OUT_W-1:0];
               rsp_set_in     = set_ext[SET_OUT_W-1:0];
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_write && (csr_paddr[2] == CSR_IDX_SEED)) begin
         lfsr_in = seed_value(csr_pwdata[LFSR_W-1:0]);
      end
   end

   // Configuration registers
   always_comb begin
      ways_log2_in = ways_log2_ff;
      seed_in      = seed_ff;
      if (csr_write) begin
         case (csr_paddr[2])
            CSR_IDX_WAYS: ways_log2_in = csr_pwdata[WAYS_CFG_W-1:0];
            CSR_IDX_SEED: seed_in      = csr_pwdata[LFSR_W-1:0];
            default: begin
               ways_log2_in = ways_log2_ff;
            end
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         CSR_IDX_WAYS: csr_prdata = CSR_DATA_W'(ways_log2_ff);
         CSR_IDX_SEED: csr_prdata = CSR_DATA_W'(seed_ff);
         default:      csr_prdata = '0;
      endcase
   end

   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         ways_log2_ff <= WAYS_LOG2_RESET;
         seed_ff      <= SEED_RESET;
         lfsr_ff      <= SEED_RESET;
         hits_ff      <= '0;
         misses_ff    <= '0;
         comp_ff      <= '0;
         cap_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         ways_log2_ff <= ways_log2_in;
         seed_ff      <= seed_in;
         lfsr_ff      <= lfsr_in;
         hits_ff      <= hits_in;
         misses_ff    <= misses_in;
         comp_ff      <= comp_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff        <= addr_in;
      way_ff         <= way_in;
      empty_found_ff <= empty_found_in;
      empty_way_ff   <= empty_way_in;
      chosen_ff      <= chosen_in;
      outcome_ff     <= outcome_in;
      rsp_outcome_ff <= rsp_outcome_in;
      rsp_way_ff     <= rsp_way_in;
      rsp_set_ff     <= rsp_set_in;
   end

   assign req_ch.ready = (state_ff == ST_IDLE);

   assign rsp_ch.valid             = rsp_valid_ff;
   assign rsp_ch.outcome           = rsp_outcome_ff;
   assign rsp_ch.way_hit_or_filled = rsp_way_ff;
   assign rsp_ch.set_used          = rsp_set_ff;
   assign rsp_ch.hit_total         = hits_ff;
   assign rsp_ch.miss_total        = misses_ff;
   assign rsp_ch.compulsory_total  = comp_ff;
   assign rsp_ch.capacity_total    = cap_ff;

endmodule

`default_nettype wire

FILE: rtl/core/scamc_tag_ram.sv
// ----------------------------------------------------------------------------
// Tag store memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module scamc_tag_ram #(
   parameter int INDEX_W = 10,
   parameter int DATA_W  = 27
) (
   input  wire logic               clock,
   input  wire logic               wr_en,
   input  wire logic [INDEX_W-1:0] wr_index,
   input  wire logic [DATA_W-1:0]  wr_data,
   input  wire logic [INDEX_W-1:0] rd_index,
   output logic      [DATA_W-1:0]  rd_data
);
   localparam int DEPTH = 1 << INDEX_W;

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_index] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_index];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: rtl/core/scamc_way_cmp.sv
// ----------------------------------------------------------------------------
// Way comparator
// Shared compare unit: checks one stored way against the lookup tag.
// ----------------------------------------------------------------------------
`default_nettype none

module scamc_way_cmp #(
   parameter int TAG_W = 26
) (
   input  wire logic                            entry_valid,
   input  wire logic [TAG_W-1:0]                entry_tag,
   input  wire logic [TAG_W-1:0]                lookup_tag,
   output scamc_pkg::cmp_result_type            result
);
   import scamc_pkg::*;

   always_comb begin
      result.hit   = entry_valid && (entry_tag == lookup_tag);
      result.empty = !entry_valid;
   end

endmodule

`default_nettype wire
